// File: design/csv_pkg.sv
// shared types and constants for the cosine similarity block
`timescale 1ns / 1ps
package csv_pkg;

    localparam int ELEM_BITS = 16;
    localparam int IN_W      = 16;
    localparam int PROD_W    = 2 * IN_W;
    localparam int ACC_W     = 44;
    localparam int MUL_W     = 32;
    localparam int WIDE_W    = 2 * ACC_W;
    localparam int QUO_W     = 32;
    localparam int ROOT_W    = QUO_W / 2;
    localparam int SIM_W     = ROOT_W + 1;
    localparam int S_DATA_W  = ((2 * IN_W + 7) / 8) * 8;
    localparam int M_BITS    = SIM_W + ACC_W + 1;
    localparam int M_DATA_W  = ((M_BITS + 7) / 8) * 8;

    // bit positions of the result fields in m_tdata
    localparam int SIM_LSB   = 0;
    localparam int DOT_LSB   = SIM_W;
    localparam int ZERO_BIT  = SIM_W + ACC_W;

    localparam logic [IN_W-1:0]  ELEM_MASK = (ELEM_BITS >= IN_W) ? {IN_W{1'b1}} :
                                             IN_W'((64'd1 << ELEM_BITS) - 64'd1);
    localparam logic [ACC_W-1:0] ACC_MAX   = {ACC_W{1'b1}};
    localparam logic [SIM_W-1:0] ONE_Q16   = SIM_W'(1) << ROOT_W;

    typedef struct packed {
        logic [ACC_W-1:0] dot;
        logic [ACC_W-1:0] norm_a;
        logic [ACC_W-1:0] norm_b;
    } csv_sums_t;

endpackage

// File: design/csv_front.sv
// front end: multiply-accumulate of element pairs, hands finished sums to the queue
`timescale 1ns / 1ps
module csv_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [csv_pkg::S_DATA_W-1:0]  s_tdata,   // elem_a, elem_b
    input  logic                          s_tlast,
    input  logic                          q_full,
    output logic                          push_valid,
    output csv_pkg::csv_sums_t            push_data
);
    import csv_pkg::*;

    logic [ACC_W-1:0]  dot_reg, dot_next;
    logic [ACC_W-1:0]  na_reg, na_next;
    logic [ACC_W-1:0]  nb_reg, nb_next;
    logic [IN_W-1:0]   elem_a, elem_b;
    logic [PROD_W-1:0] p_ab, p_aa, p_bb;
    logic              accept;

    function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] acc,
                                                 input logic [PROD_W-1:0] p);
        logic [ACC_W:0] s;
        s = {1'b0, acc} + (ACC_W + 1)'(p);
        return s[ACC_W] ? ACC_MAX : s[ACC_W-1:0];
    endfunction

    assign elem_a   = s_tdata[IN_W-1:0] & ELEM_MASK;
    assign elem_b   = s_tdata[2*IN_W-1:IN_W] & ELEM_MASK;
    assign p_ab     = PROD_W'(elem_a) * PROD_W'(elem_b);
    assign p_aa     = PROD_W'(elem_a) * PROD_W'(elem_a);
    assign p_bb     = PROD_W'(elem_b) * PROD_W'(elem_b);

    assign s_tready = ~q_full;
    assign accept   = s_tvalid & s_tready;

    assign dot_next = sat_add(dot_reg, p_ab);
    assign na_next  = sat_add(na_reg, p_aa);
    assign nb_next  = sat_add(nb_reg, p_bb);

    assign push_valid       = accept & s_tlast;
    assign push_data.dot    = dot_next;
    assign push_data.norm_a = na_next;
    assign push_data.norm_b = nb_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dot_reg <= '0;
            na_reg  <= '0;
            nb_reg  <= '0;
        end else if (accept) begin
            if (s_tlast) begin
                dot_reg <= '0;
                na_reg  <= '0;
                nb_reg  <= '0;
            end else begin
                dot_reg <= dot_next;
                na_reg  <= na_next;
                nb_reg  <= nb_next;
            end
        end
    end

endmodule

// File: design/csv_queue.sv
// two-entry queue of finished sums between front and back end
`timescale 1ns / 1ps
module csv_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push_valid,
    input  csv_pkg::csv_sums_t push_data,
    output logic               full,
    input  logic               pop,
    output logic               q_valid,
    output csv_pkg::csv_sums_t q_data
);
    import csv_pkg::*;

    csv_sums_t   mem_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic        do_push, do_pop;

    assign full    = (count_reg == 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_data  = mem_reg[rd_ptr_reg];
    assign do_push = push_valid & ~full;
    assign do_pop  = pop & q_valid;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// File: design/csv_back.sv
// back end: products, long division and square root per vector pair, output register
`timescale 1ns / 1ps
module csv_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    input  csv_pkg::csv_sums_t            q_data,
    output logic                          pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [csv_pkg::M_DATA_W-1:0]  m_tdata
);
    import csv_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_CHK,
        S_DIV,
        S_SQRT,
        S_OUT
    } state_t;

    state_t              state_reg, state_next;
    logic [ACC_W-1:0]    dot_reg, dot_next;
    logic [ACC_W-1:0]    na_reg, na_next;
    logic [ACC_W-1:0]    nb_reg, nb_next;
    logic                zero_reg, zero_next;
    logic [WIDE_W-1:0]   ab_reg, ab_next;
    logic [WIDE_W-1:0]   dd_reg, dd_next;
    logic [2*MUL_W-1:0]  prod_reg, prod_next;
    logic [2:0]          psel_reg, psel_next;
    logic [3:0]          step_reg, step_next;
    logic [WIDE_W-1:0]   rem_reg, rem_next;
    logic [QUO_W-1:0]    quo_reg, quo_next;
    logic [4:0]          cnt_reg, cnt_next;
    logic [ROOT_W-1:0]   root_reg, root_next;
    logic [3:0]          bit_reg, bit_next;
    logic [SIM_W-1:0]    sim_reg, sim_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic [ACC_W-1:0]    xsrc, ysrc;
    logic [MUL_W-1:0]    opx, opy;
    logic [1:0]          sh_cnt;
    logic [WIDE_W-1:0]   term;
    logic [WIDE_W:0]     rem2;
    logic [ROOT_W-1:0]   cand;
    logic [QUO_W-1:0]    cand_sq;
    logic [ROOT_W-1:0]   root_sel;

    function automatic logic [MUL_W-1:0] half(input logic [ACC_W-1:0] x, input logic hi);
        return hi ? MUL_W'(x[ACC_W-1:MUL_W]) : x[MUL_W-1:0];
    endfunction

    // operands of the partial product for the current step
    assign xsrc   = step_reg[2] ? dot_reg : na_reg;
    assign ysrc   = step_reg[2] ? dot_reg : nb_reg;
    assign opx    = half(xsrc, step_reg[0]);
    assign opy    = half(ysrc, step_reg[1]);
    assign sh_cnt = 2'(psel_reg[0]) + 2'(psel_reg[1]);
    assign term   = WIDE_W'(prod_reg) << (7'(sh_cnt) * 7'(MUL_W));

    assign rem2    = {rem_reg, 1'b0};
    assign cand    = root_reg | (ROOT_W'(1) << bit_reg);
    assign cand_sq = QUO_W'(cand) * QUO_W'(cand);
    assign root_sel = (cand_sq <= quo_reg) ? cand : root_reg;

    assign pop      = (state_reg == S_IDLE) & q_valid;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb begin
        state_next    = state_reg;
        dot_next      = dot_reg;
        na_next       = na_reg;
        nb_next       = nb_reg;
        zero_next     = zero_reg;
        ab_next       = ab_reg;
        dd_next       = dd_reg;
        prod_next     = prod_reg;
        psel_next     = psel_reg;
        step_next     = step_reg;
        rem_next      = rem_reg;
        quo_next      = quo_reg;
        cnt_next      = cnt_reg;
        root_next     = root_reg;
        bit_next      = bit_reg;
        sim_next      = sim_reg;
        m_tvalid_next = m_tvalid_reg & ~m_tready;
        m_tdata_next  = m_tdata_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (q_valid) begin
                    dot_next   = q_data.dot;
                    na_next    = q_data.norm_a;
                    nb_next    = q_data.norm_b;
                    zero_next  = (q_data.norm_a == '0) | (q_data.norm_b == '0);
                    ab_next    = '0;
                    dd_next    = '0;
                    step_next  = '0;
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                // product issued in one step, accumulated in the next
                if (step_reg[3] == 1'b0) begin
                    prod_next = (2 * MUL_W)'(opx) * (2 * MUL_W)'(opy);
                    psel_next = step_reg[2:0];
                end
                if (step_reg != '0) begin
                    if (psel_reg[2]) begin
                        dd_next = dd_reg + term;
                    end else begin
                        ab_next = ab_reg + term;
                    end
                end
                step_next = step_reg + 4'd1;
                if (step_reg[3]) begin
                    state_next = S_CHK;
                end
            end
            S_CHK: begin
                if (zero_reg) begin
                    sim_next   = '0;
                    state_next = S_OUT;
                end else if (dd_reg >= ab_reg) begin
                    sim_next   = ONE_Q16;
                    state_next = S_OUT;
                end else begin
                    rem_next   = dd_reg;
                    quo_next   = '0;
                    cnt_next   = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                if (rem2 >= {1'b0, ab_reg}) begin
                    rem_next = WIDE_W'(rem2 - {1'b0, ab_reg});
                    quo_next = {quo_reg[QUO_W-2:0], 1'b1};
                end else begin
                    rem_next = rem2[WIDE_W-1:0];
                    quo_next = {quo_reg[QUO_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'(QUO_W - 1)) begin
                    root_next  = '0;
                    bit_next   = 4'(ROOT_W - 1);
                    state_next = S_SQRT;
                end
            end
            S_SQRT: begin
                root_next = root_sel;
                bit_next  = bit_reg - 4'd1;
                if (bit_reg == '0) begin
                    sim_next   = SIM_W'(root_sel);
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = M_DATA_W'({zero_reg, dot_reg, sim_reg});
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            dot_reg      <= dot_next;
            na_reg       <= na_next;
            nb_reg       <= nb_next;
            zero_reg     <= zero_next;
            ab_reg       <= ab_next;
            dd_reg       <= dd_next;
            prod_reg     <= prod_next;
            psel_reg     <= psel_next;
            step_reg     <= step_next;
            rem_reg      <= rem_next;
            quo_reg      <= quo_next;
            cnt_reg      <= cnt_next;
            root_reg     <= root_next;
            bit_reg      <= bit_next;
            sim_reg      <= sim_next;
            m_tdata_reg  <= m_tdata_next;
        end
    end

endmodule

// File: design/cosine_similarity_vectors.sv
// top level of the cosine similarity block
`timescale 1ns / 1ps
// Usage
//   s_ channel: one request per element pair, s_tdata = {elem_b, elem_a}, s_tlast on the
//   final pair of a vector. Pairs are taken one per cycle while s_tready is high into
//   44-bit saturating accumulators for the dot product and both squared norms.
//   m_ channel: one request per vector, m_tdata = {pad, zero_norm, dot_product,
//   similarity}; similarity is unsigned Q1.16, rounded down, 0 when zero_norm is set.
//   After the last pair the back end forms the products norm_a*norm_b and dot*dot on one
//   32x32 multiplier, then runs a restoring division and a bitwise square root;
//   it finishes sooner when a norm is zero or the similarity is one.
//   The back end works on one vector at a time and takes the next from the queue only
//   once its result is in the output register. Two finished vectors can wait in the
//   queue; with both entries in use s_tready drops until the back end takes one.
//   A stalled m_ request holds its data while the back end keeps working on the
//   next vector.
//   Reset clears the accumulators, the queue pointers and count, and the output valid flag.
module cosine_similarity_vectors (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [csv_pkg::S_DATA_W-1:0]  s_tdata,   // elem_a, elem_b
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [csv_pkg::M_DATA_W-1:0]  m_tdata    // similarity, dot_product, zero_norm
);
    import csv_pkg::*;

    logic      push_valid;
    csv_sums_t push_data;
    logic      q_full;
    logic      q_valid;
    csv_sums_t q_data;
    logic      pop;

    csv_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .q_full     (q_full),
        .push_valid (push_valid),
        .push_data  (push_data)
    );

    csv_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_data  (push_data),
        .full       (q_full),
        .pop        (pop),
        .q_valid    (q_valid),
        .q_data     (q_data)
    );

    csv_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_valid    (q_valid),
        .q_data     (q_data),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

// File: design/csv_checker.sv
// port-level checks for the cosine similarity block, bound to the top level
`timescale 1ns / 1ps
module csv_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [csv_pkg::S_DATA_W-1:0]  s_tdata,
    input  logic                          s_tlast,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [csv_pkg::M_DATA_W-1:0]  m_tdata
);
    import csv_pkg::*;

    logic [SIM_W-1:0] sim;
    logic             zero_norm;

    assign sim       = m_tdata[SIM_LSB+SIM_W-1:SIM_LSB];
    assign zero_norm = m_tdata[ZERO_BIT];

    // result held while stalled
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_zero_sim: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && zero_norm |-> sim == '0)
        else $error("similarity not zero with zero norm");

    a_sim_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> sim <= ONE_Q16)
        else $error("similarity above one");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // input handshake known while a request is offered
    a_ready_known: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid |-> !$isunknown(s_tready) && !$isunknown({s_tdata, s_tlast}))
        else $error("input handshake unknown");

endmodule

bind cosine_similarity_vectors csv_checker u_csv_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
